// ===== hw/rtl/atan2_pkg.sv =====
// Package for the atan2 polynomial core: formats, coefficients and shared types.
// Depends on nothing; used by the core, atan2_div and atan2_poly under hw/rtl.
package atan2_pkg;

	localparam int IN_WIDTH_DEF   = 16;
	localparam int ANG_FRAC_DEF   = 13;
	localparam int RATIO_FRAC     = 17;
	localparam int COEF_FRAC      = 30;
	localparam int COEF_W         = 32;
	localparam int NUM_COEF       = 6;

	localparam logic [COEF_W-1:0] PI_Q30      = 32'd3373259426;
	localparam logic [COEF_W-1:0] HALF_PI_Q30 = 32'd1686629713;

	typedef logic signed [COEF_W-1:0] coef_t;

	function automatic coef_t poly_coef(input int k);
		coef_t c;
		unique case (k)
			0: c = 32'sd1073717407;
			1: c = -32'sd357151731;
			2: c = 32'sd207815708;
			3: c = -32'sd125018842;
			4: c = 32'sd56536072;
			default: c = -32'sd12585543;
		endcase
		return c;
	endfunction

	// Per-item side information that rides along with the data.
	typedef struct packed {
		logic valid;
		logic zero;
		logic swapped;
		logic xneg;
		logic yneg;
	} atan2_tag_t;

endpackage

// ===== hw/rtl/atan2_polynomial_approx_core.sv =====
// Channel  | Handshake          | Payload
// input    | start, busy        | x_value, y_value (signed IN_WIDTH)
// result   | done (one cycle)   | angle (signed ANGLE_FRAC_BITS+3), zero_input
// One word enters per cycle; busy stays low. A word passes through the input stage, the
// divider stages, the polynomial stages and the output stage, in that order; the
// bit-per-stage divider makes up most of the pipeline. Reset clears the tags and done.
// Data registers are not reset. The receiver cannot stall; results appear once.
// Depends on atan2_pkg, atan2_div, atan2_poly.
module atan2_polynomial_approx_core import atan2_pkg::*; #(
	parameter int IN_WIDTH        = IN_WIDTH_DEF,
	parameter int ANGLE_FRAC_BITS = ANG_FRAC_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [IN_WIDTH-1:0]        x_value,
	input  logic signed [IN_WIDTH-1:0]        y_value,
	output logic                              done,
	output logic signed [ANGLE_FRAC_BITS+2:0] angle,
	output logic                              zero_input
);

	localparam int MW = IN_WIDTH;
	localparam int AW = ANGLE_FRAC_BITS + 3;
	localparam int SH = COEF_FRAC - ANGLE_FRAC_BITS;

	assign busy = 1'b0;

	// stage 1: magnitudes and swap
	atan2_tag_t    tag_s1;
	logic [MW-1:0] small_s1, large_s1;
	logic [MW-1:0] xm, ym;
	always_comb begin
		xm = x_value[MW-1] ? MW'(-x_value) : MW'(x_value);
		ym = y_value[MW-1] ? MW'(-y_value) : MW'(y_value);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1.valid   <= start;
			tag_s1.swapped <= xm < ym;
			tag_s1.zero    <= (xm == '0) && (ym == '0);
			tag_s1.xneg    <= x_value[MW-1];
			tag_s1.yneg    <= y_value[MW-1];
		end
	end
	always_ff @(posedge clk) begin
		small_s1       <= (xm < ym) ? xm : ym;
		large_s1       <= (xm < ym) ? ym : xm;
	end

	atan2_tag_t          tag_d;
	logic [RATIO_FRAC:0] ratio_d;
	atan2_div #(.MAG_W(MW)) u_div (
		.clk, .arst_n,
		.tag_in(tag_s1), .small_in(small_s1), .large_in(large_s1),
		.tag_out(tag_d), .ratio(ratio_d)
	);

	atan2_tag_t        tag_p;
	logic [COEF_W-1:0] oct_p;
	atan2_poly u_poly (
		.clk, .arst_n,
		.tag_in(tag_d), .ratio(ratio_d),
		.tag_out(tag_p), .octant(oct_p)
	);

	// final stage: reflect, round, sign
	logic [COEF_W:0] v1, v2, vr;
	logic [AW-1:0]   mag;
	always_comb begin
		v1  = tag_p.swapped ? {1'b0, HALF_PI_Q30} - {1'b0, oct_p} : {1'b0, oct_p};
		v2  = tag_p.xneg ? {1'b0, PI_Q30} - v1 : v1;
		vr  = (v2 + ((COEF_W+1)'(1) << (SH - 1))) >> SH;
		mag = vr[AW-1:0];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= tag_p.valid;
		end
	end
	always_ff @(posedge clk) begin
		zero_input <= tag_p.zero;
		if (tag_p.zero) begin
			angle <= '0;
		end else begin
			angle <= tag_p.yneg ? AW'(-mag) : mag;
		end
	end

endmodule

// ===== hw/rtl/atan2_div.sv =====
// Pipelined restoring divider: quotient floor(small * 2^17 / large), one bit a stage.
// Depends on atan2_pkg.
module atan2_div import atan2_pkg::*; #(
	parameter int MAG_W = IN_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  atan2_tag_t         tag_in,
	input  logic [MAG_W-1:0]   small_in,
	input  logic [MAG_W-1:0]   large_in,
	output atan2_tag_t         tag_out,
	output logic [RATIO_FRAC:0] ratio
);

	localparam int STEPS = RATIO_FRAC + 1;
	localparam int REM_W = MAG_W + 1;

	atan2_tag_t          tag_s   [STEPS+1];
	logic [REM_W-1:0]    rem_s   [STEPS+1];
	logic [MAG_W-1:0]    den_s   [STEPS+1];
	logic [STEPS-1:0]    quo_s   [STEPS+1];

	always_comb begin
		tag_s[0] = tag_in;
		rem_s[0] = {1'b0, small_in};
		den_s[0] = large_in;
		quo_s[0] = '0;
	end

	// Quotient bit STEPS-1-i is resolved in stage i: small <= large so the top bit is 0 or 1.
	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic [REM_W-1:0] trial;
		logic             ge;
		logic [REM_W-1:0] rem_nx;
		always_comb begin
			ge     = rem_s[i] >= {1'b0, den_s[i]};
			trial  = rem_s[i] - {1'b0, den_s[i]};
			rem_nx = ge ? trial : rem_s[i];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[i+1] <= '0;
			end else begin
				tag_s[i+1] <= tag_s[i];
			end
		end
		always_ff @(posedge clk) begin
			rem_s[i+1]         <= {rem_nx[REM_W-2:0], 1'b0};
			den_s[i+1]         <= den_s[i];
			quo_s[i+1]         <= {quo_s[i][STEPS-2:0], ge};
		end
	end

	assign tag_out = tag_s[STEPS];
	assign ratio   = quo_s[STEPS];

endmodule

// ===== hw/rtl/atan2_poly.sv =====
// Horner evaluation of the odd polynomial, two stages per step (multiply, add).
// Depends on atan2_pkg.
module atan2_poly import atan2_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  atan2_tag_t          tag_in,
	input  logic [RATIO_FRAC:0] ratio,
	output atan2_tag_t          tag_out,
	output logic [COEF_W-1:0]   octant
);

	localparam int RW    = RATIO_FRAC + 1;
	localparam int NST   = 2 * NUM_COEF - 1;
	localparam int PW    = COEF_W + RW;
	localparam logic [PW-1:0] HALF = PW'(1) << (RATIO_FRAC - 1);

	atan2_tag_t          tag_s [NST+1];
	logic [RW-1:0]       r_s   [NST+1];
	logic [RW-1:0]       r2_s  [NST+1];
	coef_t               acc_s [NST+1];
	logic [PW-1:0]       prd_s [NST+1];
	logic                neg_s [NST+1];

	logic [2*RW-1:0] sq;
	assign sq = ratio * ratio;

	always_comb begin
		tag_s[0] = tag_in;
		r_s[0]   = ratio;
		r2_s[0]  = '0;
		acc_s[0] = poly_coef(NUM_COEF - 1);
		prd_s[0] = '0;
		neg_s[0] = 1'b0;
	end

	// Stage 0 squares the ratio; odd stages multiply by r^2, the other even stages add a coefficient.
	for (genvar i = 0; i < NST; i++) begin : g_st
		logic [COEF_W-1:0] mag;
		logic [RW-1:0]     mult;
		logic [PW-1:0]     rnd;
		coef_t             sum;
		always_comb begin
			mag  = acc_s[i][COEF_W-1] ? COEF_W'(-acc_s[i]) : acc_s[i];
			mult = r2_s[i];
			rnd  = (prd_s[i] + HALF) >> RATIO_FRAC;
			sum  = neg_s[i] ? -coef_t'(rnd[COEF_W-1:0]) : coef_t'(rnd[COEF_W-1:0]);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[i+1] <= '0;
			end else begin
				tag_s[i+1] <= tag_s[i];
			end
		end
		always_ff @(posedge clk) begin
			r_s[i+1]           <= r_s[i];
			if (i == 0) begin
				// square the ratio and round half up
				r2_s[i+1] <= RW'((sq + (2*RW)'(1 << (RATIO_FRAC - 1))) >> RATIO_FRAC);
			end else begin
				r2_s[i+1] <= r2_s[i];
			end
			if (i % 2 == 1) begin
				prd_s[i+1] <= mag * mult;
				neg_s[i+1] <= acc_s[i][COEF_W-1];
				acc_s[i+1] <= acc_s[i];
			end else if (i != 0) begin
				prd_s[i+1] <= prd_s[i];
				neg_s[i+1] <= neg_s[i];
				acc_s[i+1] <= poly_coef(NUM_COEF - 1 - i / 2) + sum;
			end else begin
				prd_s[i+1] <= prd_s[i];
				neg_s[i+1] <= neg_s[i];
				acc_s[i+1] <= acc_s[i];
			end
		end
	end

	// Form the final product acc * r in one more stage.
	logic [PW-1:0] fin_prd;
	logic [PW-1:0] fin_rnd;
	logic [COEF_W-1:0] fin_mag;
	logic              fin_neg;
	atan2_tag_t        tag_f;
	always_comb begin
		fin_mag = acc_s[NST][COEF_W-1] ? COEF_W'(-acc_s[NST]) : acc_s[NST];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_f <= '0;
		end else begin
			tag_f <= tag_s[NST];
		end
	end
	always_ff @(posedge clk) begin
		fin_prd       <= fin_mag * r_s[NST];
		fin_neg       <= acc_s[NST][COEF_W-1];
	end
	always_comb begin
		fin_rnd = (fin_prd + HALF) >> RATIO_FRAC;
		// negative result clamps to zero
		octant  = fin_neg ? '0 : fin_rnd[COEF_W-1:0];
	end
	assign tag_out = tag_f;

endmodule

// ===== hw/rtl/atan2_chk.sv =====
// Port-level checker for the atan2 core, bound to the top level.
// Depends on atan2_polynomial_approx_core.
module atan2_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        busy,
	input logic        done,
	input logic [15:0] angle,
	input logic        zero_input
);

	a_nobusy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && zero_input |-> angle == 16'd0) else $error("zero word nonzero angle");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($signed(angle) <= 16'sd25736 && $signed(angle) >= -16'sd25736))
		else $error("angle out of range");

endmodule

bind atan2_polynomial_approx_core atan2_chk u_chk (
	.clk(clk), .arst_n(arst_n), .busy(busy), .done(done),
	.angle(angle), .zero_input(zero_input)
);

// ===== verif/testbench.sv =====
// Self-checking testbench for atan2_polynomial_approx_core: directed table, then random words.
// Depends on atan2_pkg and the core RTL; predicts angles the table does not give with a fixed-point Horner model.
`timescale 1ns / 100ps

module testbench;
	import atan2_pkg::*;

	localparam int IW = 16;
	localparam int AW = 16;
	localparam int PIPE_LAT = 1 + (RATIO_FRAC + 1) + 2 * NUM_COEF + 1;
	localparam int N_RAND = 1630;

	typedef struct {
		logic signed [AW-1:0] angle;
		logic                 zero;
	} angle_word_t;

	typedef struct {
		logic signed [IW-1:0] x;
		logic signed [IW-1:0] y;
		bit                   typed;
		logic signed [AW-1:0] angle;
		logic                 zero;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic signed [IW-1:0] x_value = '0;
	logic signed [IW-1:0] y_value = '0;
	logic                 busy;
	logic                 done;
	logic signed [AW-1:0] angle;
	logic                 zero_input;

	angle_word_t angle_q[$];
	int          n_err = 0;
	int          idle_pct = 6;

	atan2_polynomial_approx_core u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.x_value(x_value), .y_value(y_value),
		.done(done), .angle(angle), .zero_input(zero_input)
	);

	always #5 clk = ~clk;

	// round(a*b / 2^17), half away from zero on the magnitude
	function automatic longint mul_rnd(longint a, longint b);
		longint m;
		m = (a < 0) ? -a : a;
		m = (m * b + (64'sd1 <<< (RATIO_FRAC - 1))) >>> RATIO_FRAC;
		return (a < 0) ? -m : m;
	endfunction

	function automatic angle_word_t predict_angle(logic signed [IW-1:0] x,
			logic signed [IW-1:0] y);
		angle_word_t w;
		longint xm, ym, sm, lg, r, r2, acc, v;
		longint cf[6];
		bit swp;
		cf = '{64'sd1073717407, -64'sd357151731, 64'sd207815708,
			-64'sd125018842, 64'sd56536072, -64'sd12585543};
		xm = (x < 0) ? -longint'(x) : longint'(x);
		ym = (y < 0) ? -longint'(y) : longint'(y);
		swp = xm < ym;
		sm = swp ? xm : ym;
		lg = swp ? ym : xm;
		if (lg == 0) begin
			w.angle = '0;
			w.zero = 1'b1;
			return w;
		end
		r = (sm <<< RATIO_FRAC) / lg;
		r2 = (r * r + (64'sd1 <<< (RATIO_FRAC - 1))) >>> RATIO_FRAC;
		acc = cf[5];
		for (int k = 4; k >= 0; k--)
			acc = cf[k] + mul_rnd(acc, r2);
		acc = mul_rnd(acc, r);
		if (acc < 0)
			acc = 0;
		v = acc;
		if (swp)
			v = longint'(HALF_PI_Q30) - v;
		if (x < 0)
			v = longint'(PI_Q30) - v;
		v = (v + (64'sd1 <<< (COEF_FRAC - 13 - 1))) >>> (COEF_FRAC - 13);
		if (y < 0)
			v = -v;
		w.angle = v[AW-1:0];
		w.zero = 1'b0;
		return w;
	endfunction

	task automatic send_word(logic signed [IW-1:0] x, logic signed [IW-1:0] y,
			angle_word_t exp_w);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		x_value <= x;
		y_value <= y;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		angle_q = {angle_q, exp_w};
	endtask

	// check each strobed result against the oldest expected word
	always @(posedge clk) begin
		angle_word_t e;
		if (arst_n && done) begin
			if (angle_q.size() == 0) begin
				$display("%0t: unexpected word angle=%0d zero=%0b", $time, angle, zero_input);
				n_err++;
			end else begin
				e = angle_q.pop_front();
				if (angle !== e.angle) begin
					$display("%0t: angle expected %0d actual %0d", $time, e.angle, angle);
					n_err++;
				end
				if (zero_input !== e.zero) begin
					$display("%0t: zero_input expected %0b actual %0b", $time, e.zero,
						zero_input);
					n_err++;
				end
			end
		end
	end

	function automatic logic signed [IW-1:0] rand_field();
		case ($urandom_range(9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return '0;
			3: return 16'($urandom_range(7) - 3);
			4: return 16'($urandom_range(255)) - 16'sd128;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		stim_row_t rows[22] = '{
			'{16'sd0, 16'sd0, 1, 16'sd0, 1'b1},
			'{16'sd100, 16'sd0, 1, 16'sd0, 1'b0},
			'{-16'sd100, 16'sd0, 1, 16'sd25736, 1'b0},
			'{16'sd0, 16'sd5, 1, 16'sd12868, 1'b0},
			'{16'sd0, -16'sd5, 1, -16'sd12868, 1'b0},
			'{16'sh8000, 16'sd0, 1, 16'sd25736, 1'b0},
			'{16'sd0, 16'sh8000, 1, -16'sd12868, 1'b0},
			'{16'sh7fff, 16'sd0, 1, 16'sd0, 1'b0},
			'{16'sd1, 16'sd1, 0, '0, 0},
			'{-16'sd1, 16'sd1, 0, '0, 0},
			'{-16'sd1, -16'sd1, 0, '0, 0},
			'{16'sd1, -16'sd1, 0, '0, 0},
			'{16'sh8000, 16'sh8000, 0, '0, 0},
			'{16'sh7fff, 16'sh7fff, 0, '0, 0},
			'{16'sh7fff, 16'sh8000, 0, '0, 0},
			'{16'sh8000, 16'sh7fff, 0, '0, 0},
			'{16'sd1, 16'sh7fff, 0, '0, 0},
			'{16'sh7fff, 16'sd1, 0, '0, 0},
			'{-16'sd3, 16'sd2, 0, '0, 0},
			'{16'sd3, -16'sd7, 0, '0, 0},
			'{16'sh5555, -16'sh2aaa, 0, '0, 0},
			'{-16'sh2aaa, -16'sh5555, 0, '0, 0}
		};
		angle_word_t w;
		int t0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) begin
			if (rows[i].typed) begin
				w.angle = rows[i].angle;
				w.zero = rows[i].zero;
			end else
				w = predict_angle(rows[i].x, rows[i].y);
			send_word(rows[i].x, rows[i].y, w);
		end
		for (int i = 0; i < N_RAND; i++) begin
			logic signed [IW-1:0] x, y;
			// sweep idle rates: sender light, then heavy, then none
			idle_pct = (i < N_RAND / 3) ? 6 : (i < 2 * N_RAND / 3) ? 62 : 0;
			x = rand_field();
			y = rand_field();
			send_word(x, y, predict_angle(x, y));
		end
		start <= 1'b0;
		t0 = 0;
		while (angle_q.size() != 0 && t0 < 10 * PIPE_LAT) begin
			@(posedge clk);
			t0++;
		end
		repeat (PIPE_LAT + 4) @(posedge clk);
		if (n_err == 0 && angle_q.size() == 0)
			$display("atan2_polynomial_approx_core regression: pass");
		else
			$display("atan2_polynomial_approx_core regression: fail");
		$finish;
	end

	initial begin
		#2000000;
		$display("atan2_polynomial_approx_core regression: fail");
		$finish;
	end

endmodule
